### rtl/xld_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xld_pkg: shared definitions for the x86 subset length decoder
// Opcode and prefix constants, pipeline stage records and byte helpers.
// ----------------------------------------------------------------------------
package xld_pkg;

   // Field widths
   localparam int HEAD_W   = 48;
   localparam int LENGTH_W = 4;
   localparam int OFFSET_W = 3;

   // Prefixes
   localparam logic [7:0] OPSIZE_PREFIX = 8'h66;
   localparam logic [7:0] REX_MASK      = 8'hF0;
   localparam logic [7:0] REX_BASE      = 8'h40;

   // Opcodes and opcode ranges
   localparam logic [7:0] PUSH_FIRST    = 8'h50;
   localparam logic [7:0] PUSH_LAST     = 8'h57;
   localparam logic [7:0] MOV_IMM_FIRST = 8'hB8;
   localparam logic [7:0] MOV_IMM_LAST  = 8'hBF;
   localparam logic [7:0] GRP1_IMM8     = 8'h83;
   localparam logic [7:0] GRP1_IMMV     = 8'h81;
   localparam logic [7:0] GRP1_BYTE     = 8'h80;
   localparam logic [7:0] ESCAPE_0F     = 8'h0F;
   localparam logic [7:0] MOVZX_B       = 8'hB6;
   localparam logic [7:0] MOVZX_W       = 8'hB7;

   // Plain ModRM forms
   localparam logic [7:0] OP_ADD_MR  = 8'h01;
   localparam logic [7:0] OP_ADD_RM  = 8'h03;
   localparam logic [7:0] OP_SUB_MR  = 8'h29;
   localparam logic [7:0] OP_SUB_RM  = 8'h2B;
   localparam logic [7:0] OP_XOR_MR  = 8'h31;
   localparam logic [7:0] OP_XOR_RM  = 8'h33;
   localparam logic [7:0] OP_CMP_MR  = 8'h39;
   localparam logic [7:0] OP_CMP_RM  = 8'h3B;
   localparam logic [7:0] OP_TEST_MR = 8'h85;
   localparam logic [7:0] OP_MOV_MR  = 8'h89;
   localparam logic [7:0] OP_MOV_RM  = 8'h8B;
   localparam logic [7:0] OP_LEA     = 8'h8D;

   // ModRM field codes
   localparam logic [1:0] MOD_INDIRECT = 2'd0;
   localparam logic [1:0] MOD_DISP8    = 2'd1;
   localparam logic [1:0] MOD_DISP32   = 2'd2;
   localparam logic [1:0] MOD_REGISTER = 2'd3;
   localparam logic [2:0] RM_SIB       = 3'd4;
   localparam logic [2:0] RM_DISP_ONLY = 3'd5;

   // After prefix decode
   typedef struct packed {
      logic [HEAD_W-1:0] head_bytes;
      logic [1:0]        head;
      logic              opsize;
      logic              rexw;
   } prefix_type;

   // After opcode decode
   typedef struct packed {
      logic                fixed_form;   // push or mov r,imm: length known
      logic                modrm_form;
      logic [LENGTH_W-1:0] fixed_len;
      logic [2:0]          modrm_at;     // byte index of ModRM
      logic [3:0]          imm;
      logic [7:0]          modrm;
      logic [2:0]          sib_base;
   } opcode_type;

   // Byte of the window at index idx; bytes past the window read as zero
   function automatic logic [7:0] byte_at(logic [HEAD_W-1:0] w, logic [2:0] idx);
      logic [7:0] b;
      case (idx)
         3'd0:    b = w[7:0];
         3'd1:    b = w[15:8];
         3'd2:    b = w[23:16];
         3'd3:    b = w[31:24];
         3'd4:    b = w[39:32];
         3'd5:    b = w[47:40];
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage
`default_nettype wire

### rtl/xld_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xld_if: request and response channels of the length decoder
// Valid/ready streams; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface xld_req_if;
   logic                           valid;
   logic                           ready;
   logic [xld_pkg::HEAD_W-1:0]     head_bytes;

   modport source (output valid, output head_bytes, input ready);
   modport sink   (input valid, input head_bytes, output ready);
endinterface

interface xld_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [xld_pkg::LENGTH_W-1:0]   insn_length;
   logic [xld_pkg::OFFSET_W-1:0]   rip_disp_offset;

   modport source (output valid, output insn_length, output rip_disp_offset, input ready);
   modport sink   (input valid, input insn_length, input rip_disp_offset, output ready);
endinterface
`default_nettype wire

### rtl/x86_subset_length_decoder_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// x86_subset_length_decoder_core: x86-64 subset instruction length decoder
// Three-stage pipeline: prefix decode, opcode decode, ModRM span and result.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries head_bytes, the first six bytes of one instruction
//   (byte 0 in bits 7:0). rsp_chan returns insn_length (0 = unsupported)
//   and rip_disp_offset (byte offset of a RIP-relative disp32, 0 = none).
//   Exactly one response per request, in request order.
// Pipeline and throughput:
//   A request accepted on req_chan passes the stage 1, stage 2 and stage 3
//   registers in that order before it is shown on rsp_chan.
//   One request per cycle is taken when the response side keeps up; the
//   figure is set by the three registered stages, each with its own valid.
// Stall:
//   Each stage holds while the stage after it is full and not taking data,
//   so a stalled rsp_chan backs up the pipe; empty stages still fill, so the
//   pipe holds up to three requests, the waiting response among them.
//   Nothing is lost or repeated.
// Reset:
//   Synchronous reset empties all stages; req_chan.ready is held low while
//   reset is high and rises as soon as reset drops. There is no other state.
// ----------------------------------------------------------------------------
module x86_subset_length_decoder_core (
   input  wire         clock,
   input  wire         reset,
   xld_req_if.sink     req_chan,
   xld_rsp_if.source   rsp_chan
);

   // Stage handshake
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic s1_ready, s2_ready, s3_ready;

   assign s3_ready = !s3_valid_ff || rsp_chan.ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign req_chan.ready = s1_ready && !reset;

   // ---------------- Stage 1: prefix decode ----------------
   xld_pkg::prefix_type s1_in, s1_ff;
   logic [7:0] rex_cand;
   logic       is_rex;

   always_comb begin
      s1_in.head_bytes = req_chan.head_bytes;
      s1_in.opsize     = (req_chan.head_bytes[7:0] == xld_pkg::OPSIZE_PREFIX);
      rex_cand         = s1_in.opsize ? req_chan.head_bytes[15:8]
                                      : req_chan.head_bytes[7:0];
      is_rex           = ((rex_cand & xld_pkg::REX_MASK) == xld_pkg::REX_BASE);
      s1_in.rexw       = is_rex && rex_cand[3];
      s1_in.head       = {1'b0, s1_in.opsize} + {1'b0, is_rex};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_chan.valid;
      end
      if (s1_ready && req_chan.valid) begin
         s1_ff <= s1_in;
      end
   end

   // ---------------- Stage 2: opcode decode ----------------
   xld_pkg::opcode_type s2_in, s2_ff;
   logic [7:0] op_byte, esc_byte;
   logic [1:0] opc;
   logic [3:0] movimm_imm;

   always_comb begin
      op_byte  = xld_pkg::byte_at(s1_ff.head_bytes, {1'b0, s1_ff.head});
      esc_byte = xld_pkg::byte_at(s1_ff.head_bytes, {1'b0, s1_ff.head} + 3'd1);
      opc      = 2'd1;
      movimm_imm = s1_ff.rexw ? 4'd8 : (s1_ff.opsize ? 4'd2 : 4'd4);

      s2_in.fixed_form = 1'b0;
      s2_in.modrm_form = 1'b0;
      s2_in.fixed_len  = '0;
      s2_in.imm        = '0;

      if (op_byte >= xld_pkg::PUSH_FIRST && op_byte <= xld_pkg::PUSH_LAST) begin
         s2_in.fixed_form = 1'b1;
         s2_in.fixed_len  = {2'b00, s1_ff.head} + 4'd1;
      end else if (op_byte >= xld_pkg::MOV_IMM_FIRST && op_byte <= xld_pkg::MOV_IMM_LAST) begin
         s2_in.fixed_form = 1'b1;
         s2_in.fixed_len  = {2'b00, s1_ff.head} + 4'd1 + movimm_imm;
      end else begin
         case (op_byte)
            xld_pkg::OP_ADD_MR, xld_pkg::OP_ADD_RM,
            xld_pkg::OP_SUB_MR, xld_pkg::OP_SUB_RM,
            xld_pkg::OP_XOR_MR, xld_pkg::OP_XOR_RM,
            xld_pkg::OP_CMP_MR, xld_pkg::OP_CMP_RM,
            xld_pkg::OP_TEST_MR, xld_pkg::OP_MOV_MR,
            xld_pkg::OP_MOV_RM, xld_pkg::OP_LEA: begin
               s2_in.modrm_form = 1'b1;
            end
            xld_pkg::GRP1_IMM8, xld_pkg::GRP1_BYTE: begin
               s2_in.modrm_form = 1'b1;
               s2_in.imm        = 4'd1;
            end
            xld_pkg::GRP1_IMMV: begin
               s2_in.modrm_form = 1'b1;
               s2_in.imm        = (s1_ff.opsize && !s1_ff.rexw) ? 4'd2 : 4'd4;
            end
            xld_pkg::ESCAPE_0F: begin
               if (esc_byte == xld_pkg::MOVZX_B || esc_byte == xld_pkg::MOVZX_W) begin
                  s2_in.modrm_form = 1'b1;
                  opc              = 2'd2;
               end
            end
            default: begin
            end
         endcase
      end

      // ModRM and SIB bytes for the last stage
      s2_in.modrm_at = {1'b0, s1_ff.head} + {1'b0, opc};
      s2_in.modrm    = xld_pkg::byte_at(s1_ff.head_bytes, s2_in.modrm_at);
      s2_in.sib_base = 3'(xld_pkg::byte_at(s1_ff.head_bytes, s2_in.modrm_at + 3'd1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_ff <= s2_in;
      end
   end

   // ---------------- Stage 3: ModRM span and result ----------------
   logic [1:0] mod_f;
   logic [2:0] rm_f;
   logic [2:0] span;
   logic       refused, riprel;
   logic [xld_pkg::LENGTH_W-1:0] length_in, length_ff;
   logic [xld_pkg::OFFSET_W-1:0] offset_in, offset_ff;

   always_comb begin
      mod_f   = s2_ff.modrm[7:6];
      rm_f    = s2_ff.modrm[2:0];
      refused = 1'b0;
      riprel  = 1'b0;
      span    = 3'd1;
      if (mod_f != xld_pkg::MOD_REGISTER) begin
         if (rm_f == xld_pkg::RM_SIB) begin
            span = 3'd2;
            // SIB with no base register
            refused = (mod_f == xld_pkg::MOD_INDIRECT) &&
                      (s2_ff.sib_base == xld_pkg::RM_DISP_ONLY);
         end else if (mod_f == xld_pkg::MOD_INDIRECT && rm_f == xld_pkg::RM_DISP_ONLY) begin
            riprel = 1'b1;
            span   = 3'd5;
         end
         if (!riprel) begin
            if (mod_f == xld_pkg::MOD_DISP8) begin
               span = span + 3'd1;
            end else if (mod_f == xld_pkg::MOD_DISP32) begin
               span = span + 3'd4;
            end
         end
      end

      length_in = '0;
      offset_in = '0;
      if (s2_ff.fixed_form) begin
         length_in = s2_ff.fixed_len;
      end else if (s2_ff.modrm_form && !refused) begin
         length_in = {1'b0, s2_ff.modrm_at} + {1'b0, span} + s2_ff.imm;
         if (riprel) begin
            offset_in = s2_ff.modrm_at + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_ready) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (s3_ready && s2_valid_ff) begin
         length_ff <= length_in;
         offset_ff <= offset_in;
      end
   end

   assign rsp_chan.valid           = s3_valid_ff;
   assign rsp_chan.insn_length     = length_ff;
   assign rsp_chan.rip_disp_offset = offset_ff;

endmodule
`default_nettype wire

### rtl/xld_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xld_checker: port-level checks for the length decoder
// Response handshake, reset behavior and result consistency.
// ----------------------------------------------------------------------------
module xld_checker (
   input wire                           clock,
   input wire                           reset,
   input wire                           rsp_valid,
   input wire                           rsp_ready,
   input wire [xld_pkg::LENGTH_W-1:0]   insn_length,
   input wire [xld_pkg::OFFSET_W-1:0]   rip_disp_offset
);

   // Stalled response stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // Stalled response payload holds
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(insn_length) && $stable(rip_disp_offset))
      else $error("response payload changed while stalled");

   // Reset empties the pipe
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A RIP-relative disp32 lies fully inside a supported instruction
   a_disp_inside: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rip_disp_offset != '0 |->
         ({1'b0, rip_disp_offset} + 4'd4) <= insn_length)
      else $error("disp32 offset outside instruction");

endmodule

bind x86_subset_length_decoder_core xld_checker u_xld_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .insn_length     (rsp_chan.insn_length),
   .rip_disp_offset (rsp_chan.rip_disp_offset)
);
`default_nettype wire
